>>> hw/rtl/atbt_pkg.sv
// ----------------------------------------------------------------------------
// atbt_pkg
// Shared types and codes for the array binary tree engine: request actions,
// result status codes, microcode word layout and the flag bundle that the
// datapath hands to the sequencer.
// ----------------------------------------------------------------------------
package atbt_pkg;

  localparam int VAL_W = 32;
  localparam int ACT_W = 3;
  localparam int ST_W  = 3;
  localparam int LOC_W = 4;

  localparam logic [VAL_W-1:0] EMPTY_VAL = '1;

  // request actions
  localparam logic [ACT_W-1:0] ACT_SEARCH    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_LEFT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_RIGHT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ROOT      = 3'd4;

  // result status
  localparam logic [ST_W-1:0] ST_OK           = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND    = 3'd1;
  localparam logic [ST_W-1:0] ST_CHILD_EXISTS = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_LEAF     = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_ROOM      = 3'd4;

  typedef logic [3:0] upc_t;

  // datapath operation selected by the current control word
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_ROOT,
    OP_WALK,
    OP_NOP,
    OP_RDA,
    OP_RDB,
    OP_CHK
  } op_t;

  // emit shares the no-op datapath code; the output stage keys off the step
  typedef enum logic [1:0] {
    BR_SEQ,
    BR_JUMP,
    BR_IF,
    BR_WAIT
  } br_t;

  typedef enum logic [2:0] {
    F_NONE,
    F_ACCEPT,
    F_TREE,
    F_WALK_DONE,
    F_MISS,
    F_SEARCH,
    F_OUT_FREE
  } flag_t;

  typedef struct packed {
    op_t   op;
    logic  emit;
    br_t   br;
    flag_t flag;
    upc_t  target;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic tree_op;
    logic walk_done;
    logic miss;
    logic search;
    logic out_free;
  } dp_flags_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             found;
    logic [LOC_W-1:0] location;
  } result_t;

endpackage

>>> hw/rtl/atbt_ram.sv
// ----------------------------------------------------------------------------
// atbt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module atbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/atbt_useq.sv
// ----------------------------------------------------------------------------
// atbt_useq
// Microcode sequencer: step counter, control-word ROM and branch unit.
// Each step issues one datapath operation and picks the next step.
// ----------------------------------------------------------------------------
module atbt_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  atbt_pkg::dp_flags_t flags,
  output atbt_pkg::op_t       op,
  output logic                emit,
  output logic                idle
);
  import atbt_pkg::*;

  localparam upc_t U_IDLE  = 4'd0;
  localparam upc_t U_SEL   = 4'd1;
  localparam upc_t U_ROOT  = 4'd2;
  localparam upc_t U_WALK  = 4'd3;
  localparam upc_t U_FOUND = 4'd4;
  localparam upc_t U_RDA   = 4'd5;
  localparam upc_t U_RDB   = 4'd6;
  localparam upc_t U_CHK   = 4'd7;
  localparam upc_t U_EMIT  = 4'd8;

  function automatic ucode_t ucode_at(input upc_t a);
    ucode_t w;
    unique case (a)
      U_IDLE:  w = '{op: OP_IDLE, emit: 1'b0, br: BR_WAIT, flag: F_ACCEPT,    target: U_SEL};
      U_SEL:   w = '{op: OP_INIT, emit: 1'b0, br: BR_IF,   flag: F_TREE,      target: U_WALK};
      U_ROOT:  w = '{op: OP_ROOT, emit: 1'b0, br: BR_JUMP, flag: F_NONE,      target: U_EMIT};
      U_WALK:  w = '{op: OP_WALK, emit: 1'b0, br: BR_WAIT, flag: F_WALK_DONE, target: U_FOUND};
      U_FOUND: w = '{op: OP_NOP,  emit: 1'b0, br: BR_IF,   flag: F_MISS,      target: U_EMIT};
      U_RDA:   w = '{op: OP_RDA,  emit: 1'b0, br: BR_IF,   flag: F_SEARCH,    target: U_EMIT};
      U_RDB:   w = '{op: OP_RDB,  emit: 1'b0, br: BR_SEQ,  flag: F_NONE,      target: U_IDLE};
      U_CHK:   w = '{op: OP_CHK,  emit: 1'b0, br: BR_SEQ,  flag: F_NONE,      target: U_IDLE};
      U_EMIT:  w = '{op: OP_NOP,  emit: 1'b1, br: BR_WAIT, flag: F_OUT_FREE,  target: U_IDLE};
      default: w = '{op: OP_NOP,  emit: 1'b0, br: BR_JUMP, flag: F_NONE,      target: U_IDLE};
    endcase
    return w;
  endfunction

  upc_t   upc_r;
  upc_t   upc_nxt;
  ucode_t cw;
  logic   cond;

  assign cw   = ucode_at(upc_r);
  assign op   = cw.op;
  assign emit = cw.emit;
  assign idle = (upc_r == U_IDLE);

  always_comb begin
    unique case (cw.flag)
      F_NONE:      cond = 1'b0;
      F_ACCEPT:    cond = flags.accept;
      F_TREE:      cond = flags.tree_op;
      F_WALK_DONE: cond = flags.walk_done;
      F_MISS:      cond = flags.miss;
      F_SEARCH:    cond = flags.search;
      F_OUT_FREE:  cond = flags.out_free;
      default:     cond = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.br)
      BR_SEQ:  upc_nxt = upc_r + 4'd1;
      BR_JUMP: upc_nxt = cw.target;
      BR_IF:   upc_nxt = cond ? cw.target : upc_r + 4'd1;
      BR_WAIT: upc_nxt = cond ? cw.target : upc_r;
      default: upc_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> hw/rtl/atbt_dpath.sv
// ----------------------------------------------------------------------------
// atbt_dpath
// Datapath: request registers, preorder walk index unit, key comparator,
// child checks, slot RAM and per-slot valid bits.
// ----------------------------------------------------------------------------
module atbt_dpath #(
  parameter int SLOT_COUNT = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  atbt_pkg::op_t       op,
  input  logic                in_valid,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_search_key,
  input  logic signed [31:0]  in_new_value,
  input  logic                out_free,
  output atbt_pkg::dp_flags_t flags,
  output atbt_pkg::result_t   result
);
  import atbt_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int J_W   = IDX_W + 1;   // 1-based walk index, holds SLOT_COUNT
  localparam int JX_W  = IDX_W + 2;   // room for child and climb arithmetic
  localparam int TZ_W  = $clog2(JX_W);
  localparam logic [JX_W-1:0] SLOTS = JX_W'(SLOT_COUNT);

  // drop trailing zeros: climb out of finished right subtrees
  function automatic logic [JX_W-1:0] strip_tz(input logic [JX_W-1:0] v);
    logic [TZ_W-1:0] tz;
    tz = '0;
    for (int k = JX_W - 1; k >= 0; k--) begin
      if (v[k]) begin
        tz = TZ_W'(k);
      end
    end
    return v >> tz;
  endfunction

  logic [ACT_W-1:0] act_r, act_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [J_W-1:0]   walk_j_r, walk_j_nxt;
  logic             more_r, more_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] loc_r, loc_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic             a_oob_r, a_oob_nxt;
  logic             b_oob_r, b_oob_nxt;
  logic             a_empty_r, a_empty_nxt;
  logic [IDX_W-1:0] a_addr_r, a_addr_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [SLOT_COUNT-1:0] vld_r, vld_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_q;

  logic [VAL_W-1:0] rd_eff;
  logic             rd_empty;
  logic             match;

  logic [JX_W-1:0]  jx;
  logic [JX_W-1:0]  left_j;
  logic [JX_W-1:0]  up1;
  logic [JX_W-1:0]  up2;
  logic [JX_W-1:0]  up_j;
  logic [JX_W-1:0]  next_j;
  logic             next_more;
  logic [J_W-1:0]   walk_m1;
  logic [IDX_W-1:0] walk_addr;

  logic [JX_W-1:0]  child_l;
  logic [JX_W-1:0]  child_r;
  logic [JX_W-1:0]  child_a;

  atbt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // a slot never written since reset reads as empty
  assign rd_eff   = rd_vld_r ? ram_q : EMPTY_VAL;
  assign rd_empty = (rd_eff == EMPTY_VAL);
  assign match    = (rd_eff == key_r);

  // next slot in preorder, 1-based: children of j are 2j and 2j+1
  assign jx        = JX_W'(walk_j_r);
  assign left_j    = jx << 1;
  assign up1       = strip_tz(jx + JX_W'(1));
  assign up2       = strip_tz((jx >> 1) + JX_W'(1));
  assign up_j      = (up1 > SLOTS) ? up2 : up1;
  assign next_j    = (left_j <= SLOTS) ? left_j : up_j;
  assign next_more = (left_j <= SLOTS) || (up_j != JX_W'(1));
  assign walk_m1   = walk_j_r - J_W'(1);
  assign walk_addr = walk_m1[IDX_W-1:0];

  assign child_l = {1'b0, loc_r, 1'b1};
  assign child_r = {1'b0, loc_r, 1'b0} + JX_W'(2);
  assign child_a = (act_r == ACT_INS_RIGHT) ? child_r : child_l;

  always_comb begin
    act_nxt      = act_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    walk_j_nxt   = walk_j_r;
    more_nxt     = more_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    hit_nxt      = hit_r;
    loc_nxt      = loc_r;
    status_nxt   = status_r;
    a_oob_nxt    = a_oob_r;
    b_oob_nxt    = b_oob_r;
    a_empty_nxt  = a_empty_r;
    a_addr_nxt   = a_addr_r;
    vld_nxt      = vld_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (op)
      OP_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          key_nxt = in_search_key;
          val_nxt = in_new_value;
        end
      end
      OP_INIT: begin
        walk_j_nxt = J_W'(1);
        more_nxt   = 1'b1;
        pend_nxt   = 1'b0;
        hit_nxt    = 1'b0;
        loc_nxt    = '0;
        status_nxt = ST_OK;
      end
      OP_ROOT: begin
        if (act_r == ACT_ROOT) begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          vld_nxt[0] = 1'b1;
        end
      end
      OP_WALK: begin
        if (pend_r && match) begin
          hit_nxt  = 1'b1;
          loc_nxt  = pend_idx_r;
          pend_nxt = 1'b0;
        end else if (!more_r) begin
          status_nxt = ST_NOT_FOUND;
          pend_nxt   = 1'b0;
        end else begin
          // read one slot, compare it next cycle
          ram_re       = 1'b1;
          ram_raddr    = walk_addr;
          pend_nxt     = 1'b1;
          pend_idx_nxt = walk_addr;
          walk_j_nxt   = next_j[J_W-1:0];
          more_nxt     = next_more;
        end
      end
      OP_RDA: begin
        a_oob_nxt  = (child_a >= SLOTS);
        b_oob_nxt  = (child_r >= SLOTS);
        a_addr_nxt = child_a[IDX_W-1:0];
        if (child_a < SLOTS) begin
          ram_re    = 1'b1;
          ram_raddr = child_a[IDX_W-1:0];
        end
      end
      OP_RDB: begin
        a_empty_nxt = a_oob_r || rd_empty;
        if (!b_oob_r) begin
          ram_re    = 1'b1;
          ram_raddr = child_r[IDX_W-1:0];
        end
      end
      OP_CHK: begin
        if (act_r == ACT_DELETE) begin
          if (a_empty_r && (b_oob_r || rd_empty)) begin
            vld_nxt[loc_r] = 1'b0;
          end else begin
            status_nxt = ST_NOT_LEAF;
          end
        end else if (a_oob_r) begin
          status_nxt = ST_NO_ROOM;
        end else if (!a_empty_r) begin
          status_nxt = ST_CHILD_EXISTS;
        end else begin
          ram_we            = 1'b1;
          ram_waddr         = a_addr_r;
          vld_nxt[a_addr_r] = 1'b1;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase

    rd_vld_nxt = rd_vld_r;
    if (ram_re) begin
      rd_vld_nxt = vld_r[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      pend_r   <= 1'b0;
      more_r   <= 1'b0;
      hit_r    <= 1'b0;
      status_r <= ST_OK;
    end else begin
      vld_r    <= vld_nxt;
      pend_r   <= pend_nxt;
      more_r   <= more_nxt;
      hit_r    <= hit_nxt;
      status_r <= status_nxt;
    end
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    walk_j_r   <= walk_j_nxt;
    pend_idx_r <= pend_idx_nxt;
    loc_r      <= loc_nxt;
    a_oob_r    <= a_oob_nxt;
    b_oob_r    <= b_oob_nxt;
    a_empty_r  <= a_empty_nxt;
    a_addr_r   <= a_addr_nxt;
    rd_vld_r   <= rd_vld_nxt;
  end

  assign flags.accept    = in_valid;
  assign flags.tree_op   = (act_r <= ACT_DELETE);
  assign flags.walk_done = (pend_r && match) || !more_r;
  assign flags.miss      = !hit_r;
  assign flags.search    = (act_r == ACT_SEARCH);
  assign flags.out_free  = out_free;

  assign result.status   = status_r;
  assign result.found    = hit_r;
  assign result.location = LOC_W'(loc_r);

endmodule

>>> hw/rtl/array_binary_tree_engine.sv
// Throughput: one request at a time; the next request is taken once the result is loaded
//   for output and the sequencer returns to idle; the walk reads one slot per cycle.
// Reset: synchronous, active low; per-slot valid bits make every slot read as empty.
// ----------------------------------------------------------------------------
// array_binary_tree_engine
// Binary tree kept in a slot array, driven by a microcoded sequencer: search,
// insert left/right, delete leaf and set root, one result per request.
// ----------------------------------------------------------------------------
module array_binary_tree_engine #(
  parameter int SLOT_COUNT = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_search_key,
  input  logic signed [31:0] in_new_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_found,
  output logic [3:0]         out_location
);
  import atbt_pkg::*;

  op_t       op;
  logic      emit;
  logic      idle;
  dp_flags_t flags;
  result_t   result;
  logic      out_free;
  logic      load;

  logic      out_valid_r, out_valid_nxt;
  result_t   out_res_r;

  atbt_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op),
    .emit  (emit),
    .idle  (idle)
  );

  atbt_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_search_key (in_search_key),
    .in_new_value  (in_new_value),
    .out_free      (out_free),
    .flags         (flags),
    .result        (result)
  );

  assign in_stall = !idle;

  // hold the result until taken; load a new one once the slot frees
  assign out_free = !out_valid_r || !out_stall;
  assign load     = emit && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      out_res_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_res_r.status;
  assign out_found    = out_res_r.found;
  assign out_location = out_res_r.location;

endmodule
